// ===== rtl/sm3_hash_engine_macros.svh =====
// ---------------------------------------------------------------------------
// SM3 hash engine assertion macros
// Shared helpers for the concurrent checks, clocked on clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef SM3_HASH_ENGINE_MACROS_SVH
`define SM3_HASH_ENGINE_MACROS_SVH

// same-cycle implication
`define SM3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SM3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sm3_pkg.sv =====
// ---------------------------------------------------------------------------
// SM3 package
// Beat types, queue entry type, algorithm constants and helper functions.
// ---------------------------------------------------------------------------
package sm3_pkg;

  localparam int LEN_W     = 61;
  localparam int CMD_DEPTH = 4;
  localparam int CMD_AW    = 2;

  localparam logic [31:0] SM3_T_LO  = 32'h79CC_4519;
  localparam logic [31:0] SM3_T_HI  = 32'h7A87_9D8A;
  localparam logic [31:0] PAD_WORD  = 32'h8000_0000;
  localparam logic [3:0]  FILL_LEN  = 4'd14;
  localparam logic [3:0]  FILL_LAST = 4'd15;
  localparam logic [2:0]  NB_FULL   = 3'd4;

  localparam logic [31:0] SM3_IV [8] = '{
    32'h7380_166F, 32'h4914_B2B9, 32'h1724_42D7, 32'hDA8A_0600,
    32'hA96F_30BC, 32'h1631_38AA, 32'hE38D_EE4D, 32'hB0FB_0E4E
  };

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // classified word as queued for the back end
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nb;
    logic        fin;
    logic        pad80;
  } cmd_t;

  function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] tmp;
    tmp = {x, x} << n;
    return tmp[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rol32(x, 5'd9) ^ rol32(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rol32(x, 5'd15) ^ rol32(x, 5'd23);
  endfunction

endpackage

// ===== rtl/sm3_front.sv =====
// ---------------------------------------------------------------------------
// SM3 front end
// Normalises the byte count and builds the padded word of a final beat.
// ---------------------------------------------------------------------------
module sm3_front (
  input  logic             in_push,
  input  sm3_pkg::in_item_t in_item,
  output logic             in_full,
  input  logic             q_full,
  output logic             q_push,
  output sm3_pkg::cmd_t    q_cmd
);
  import sm3_pkg::*;

  logic [2:0]  nb;
  logic [31:0] padw;

  always_comb begin
    if (!in_item.last || in_item.byte_count > NB_FULL) begin
      nb = NB_FULL;
    end else begin
      nb = in_item.byte_count;
    end
    case (nb)
      3'd0:    padw = PAD_WORD;
      3'd1:    padw = {in_item.data_word[31:24], 24'h80_0000};
      3'd2:    padw = {in_item.data_word[31:16], 16'h8000};
      3'd3:    padw = {in_item.data_word[31:8], 8'h80};
      default: padw = in_item.data_word;
    endcase
  end

  assign q_cmd.word  = padw;
  assign q_cmd.nb    = nb;
  assign q_cmd.fin   = in_item.last;
  assign q_cmd.pad80 = in_item.last && (nb == NB_FULL);
  assign q_push      = in_push && !q_full;
  assign in_full     = q_full;

endmodule

// ===== rtl/sm3_cmd_fifo.sv =====
// ---------------------------------------------------------------------------
// SM3 command queue
// Short register queue between front end and compression back end.
// ---------------------------------------------------------------------------
module sm3_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sm3_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          pop,
  output sm3_pkg::cmd_t rd_cmd,
  output logic          empty
);
  import sm3_pkg::*;

  cmd_t              mem_r [CMD_DEPTH];
  logic [CMD_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_AW:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == CMD_AW'(0) + (CMD_AW+1)'(CMD_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_cmd  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/sm3_back.sv =====
// ---------------------------------------------------------------------------
// SM3 back end
// Block window, padding sequencer, one-round-per-cycle compression and the
// eight-word digest bank.
// ---------------------------------------------------------------------------
`include "sm3_hash_engine_macros.svh"

module sm3_back (
  input  logic              clk,
  input  logic              rst_n,
  input  sm3_pkg::cmd_t     cmd,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output sm3_pkg::out_item_t out_item
);
  import sm3_pkg::*;

  typedef enum logic [2:0] {
    S_TAKE, S_PAD80, S_ZERO, S_LENHI, S_LENLO, S_COMP, S_DONE
  } state_t;

  state_t           state_r, state_nxt, ret_r, ret_nxt, logical;
  logic [3:0]       fill_r, fill_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [5:0]       round_r, round_nxt;
  logic [31:0]      win_r [16];
  logic [31:0]      win_nxt [16];
  logic [31:0]      cv_r [8];
  logic [31:0]      cv_nxt [8];
  logic [31:0]      wk_r [8];
  logic [31:0]      wk_nxt [8];
  logic [31:0]      obank_r [8];
  logic [31:0]      obank_nxt [8];
  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       out_idx_r, out_idx_nxt;

  logic        push_en;
  logic [31:0] push_w;
  logic [31:0] t_rot, a12, ss1, ss2, ff, gg, tt1, tt2, w_new;
  logic [31:0] rnd [8];

  // single round of the compression, window holds W[j..j+15]
  always_comb begin
    t_rot = rol32((round_r < 6'd16) ? SM3_T_LO : SM3_T_HI, round_r[4:0]);
    a12   = rol32(wk_r[0], 5'd12);
    ss1   = rol32(a12 + wk_r[4] + t_rot, 5'd7);
    ss2   = ss1 ^ a12;
    if (round_r < 6'd16) begin
      ff = wk_r[0] ^ wk_r[1] ^ wk_r[2];
      gg = wk_r[4] ^ wk_r[5] ^ wk_r[6];
    end else begin
      ff = (wk_r[0] & wk_r[1]) | (wk_r[0] & wk_r[2]) | (wk_r[1] & wk_r[2]);
      gg = (wk_r[4] & wk_r[5]) | (~wk_r[4] & wk_r[6]);
    end
    tt1    = ff + wk_r[3] + ss2 + (win_r[0] ^ win_r[4]);
    tt2    = gg + wk_r[7] + ss1 + win_r[0];
    rnd[0] = tt1;
    rnd[1] = wk_r[0];
    rnd[2] = rol32(wk_r[1], 5'd9);
    rnd[3] = wk_r[2];
    rnd[4] = perm0(tt2);
    rnd[5] = wk_r[4];
    rnd[6] = rol32(wk_r[5], 5'd19);
    rnd[7] = wk_r[6];
    w_new  = perm1(win_r[0] ^ win_r[7] ^ rol32(win_r[13], 5'd15))
             ^ rol32(win_r[3], 5'd7) ^ win_r[10];
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    logical       = state_r;
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    round_nxt     = round_r;
    win_nxt       = win_r;
    cv_nxt        = cv_r;
    wk_nxt        = wk_r;
    obank_nxt     = obank_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    push_en       = 1'b0;
    push_w        = '0;
    cmd_pop       = 1'b0;

    case (state_r)
      S_TAKE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          push_en = 1'b1;
          push_w  = cmd.word;
          len_nxt = len_r + LEN_W'(cmd.nb);
          if (!cmd.fin) begin
            logical = S_TAKE;
          end else if (cmd.pad80) begin
            logical = S_PAD80;
          end else begin
            logical = S_ZERO;
          end
        end
      end
      S_PAD80: begin
        push_en = 1'b1;
        push_w  = PAD_WORD;
        logical = S_ZERO;
      end
      S_ZERO: begin
        if (fill_r == FILL_LEN) begin
          state_nxt = S_LENHI;
        end else begin
          push_en = 1'b1;
          logical = S_ZERO;
        end
      end
      S_LENHI: begin
        push_en = 1'b1;
        push_w  = len_r[LEN_W-1:29];
        logical = S_LENLO;
      end
      S_LENLO: begin
        push_en = 1'b1;
        push_w  = {len_r[28:0], 3'b000};
        logical = S_DONE;
      end
      S_COMP: begin
        wk_nxt = rnd;
        for (int i = 0; i < 15; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[15] = w_new;
        round_nxt   = round_r + 1'b1;
        if (round_r == 6'd63) begin
          for (int i = 0; i < 8; i++) begin
            cv_nxt[i] = cv_r[i] ^ rnd[i];
          end
          state_nxt = ret_r;
        end
      end
      S_DONE: begin
        // hold the finished digest until the bank has drained
        if (!out_valid_r) begin
          obank_nxt     = cv_r;
          out_valid_nxt = 1'b1;
          out_idx_nxt   = '0;
          cv_nxt        = SM3_IV;
          len_nxt       = '0;
          state_nxt     = S_TAKE;
        end
      end
      default: state_nxt = S_TAKE;
    endcase

    if (push_en) begin
      for (int i = 0; i < 15; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      win_nxt[15] = push_w;
      fill_nxt    = fill_r + 1'b1;
      if (fill_r == FILL_LAST) begin
        state_nxt = S_COMP;
        ret_nxt   = logical;
        wk_nxt    = cv_r;
        round_nxt = '0;
      end else begin
        state_nxt = logical;
      end
    end

    if (out_pop && out_valid_r) begin
      for (int i = 0; i < 7; i++) begin
        obank_nxt[i] = obank_r[i+1];
      end
      obank_nxt[7] = obank_r[7];
      out_idx_nxt  = out_idx_r + 1'b1;
      if (out_idx_r == 3'd7) begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    win_r   <= win_nxt;
    wk_r    <= wk_nxt;
    obank_r <= obank_nxt;
    if (!rst_n) begin
      state_r     <= S_TAKE;
      ret_r       <= S_TAKE;
      fill_r      <= '0;
      len_r       <= '0;
      round_r     <= '0;
      cv_r        <= SM3_IV;
      out_valid_r <= 1'b0;
      out_idx_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      round_r     <= round_nxt;
      cv_r        <= cv_nxt;
      out_valid_r <= out_valid_nxt;
      out_idx_r   <= out_idx_nxt;
    end
  end

  assign out_empty            = !out_valid_r;
  assign out_item.digest_word = obank_r[0];
  assign out_item.word_index  = out_idx_r;
  assign out_item.last_word   = (out_idx_r == 3'd7);

  `SM3_ASSERT_NOW(a_round_idle, state_r != S_COMP, round_r == '0, "round counter left running")
  `SM3_ASSERT_NEXT(a_comp_ends, (state_r == S_COMP) && (round_r == 6'd63), state_r != S_COMP, "compression overran 64 rounds")
  `SM3_ASSERT_NOW(a_lenhi_slot, state_r == S_LENHI, fill_r == FILL_LEN, "length word misplaced in block")
  `SM3_ASSERT_NOW(a_lenlo_slot, state_r == S_LENLO, fill_r == FILL_LAST, "low length word misplaced")
  `SM3_ASSERT_NEXT(a_bank_load, (state_r == S_DONE) && !out_valid_r, out_valid_r && (out_idx_r == 3'd0), "digest bank not loaded")

endmodule

// ===== rtl/sm3_hash_engine.sv =====
// ---------------------------------------------------------------------------
// SM3 hash engine
// Streams big-endian message words and returns the 256-bit SM3 digest.
// ---------------------------------------------------------------------------
// Input beats go through a four-entry queue, so the input side takes one beat
// a cycle until the queue fills. The back end moves one queued word into the
// block window per cycle when not compressing; every sixteenth word starts a
// compression of 64 rounds at one round per cycle. After the final beat come
// the padding and length words, a step without a push ahead of the length
// words, one or two compressions and the load of the output bank; the eight
// digest words are then popped from the output bank one per beat, most
// significant first.
// The next message proceeds meanwhile and waits only if its digest is ready
// before the bank has drained.
module sm3_hash_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  sm3_pkg::in_item_t  in_item,
  output logic               in_full,
  output logic               out_empty,
  input  logic               out_pop,
  output sm3_pkg::out_item_t out_item
);
  import sm3_pkg::*;

  cmd_t q_wr_cmd, q_rd_cmd;
  logic q_push, q_full, q_pop, q_empty;

  sm3_front u_front (
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_wr_cmd)
  );

  sm3_cmd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_cmd (q_wr_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .rd_cmd (q_rd_cmd),
    .empty  (q_empty)
  );

  sm3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_rd_cmd),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
